// File: sv/sctio_pkg.sv
// Shared types and constants for the sound CPU timer and I/O register block.
// Used by every module in this folder; depends on nothing.
package sctio_pkg;

  localparam int TIMER_COUNT = 3;
  localparam int PORT_COUNT  = 4;
  // Only three timers have enable bits in the control byte.
  localparam int PAGE_TIMERS = 3;
  localparam int CTRL_TIMERS = (TIMER_COUNT < PAGE_TIMERS) ? TIMER_COUNT : PAGE_TIMERS;

  // Page offsets
  localparam int OFF_CONTROL     = 1;
  localparam int OFF_ADDR        = 2;
  localparam int OFF_PORT_BASE   = 4;
  localparam int OFF_PORT_LAST   = 7;
  localparam int OFF_TARGET_BASE = 10;
  localparam int OFF_COUNT_BASE  = 13;

  // Control byte bits
  localparam int CTRL_CLR_LO_BIT = 4;
  localparam int CTRL_CLR_HI_BIT = 5;
  localparam int CTRL_ROM_BIT    = 7;

  localparam logic [7:0] UNMAPPED_BYTE = 8'hff;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_HOST  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic [1:0] timer_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rom_visible;
    logic [2:0] timers_enabled;
  } out_item_t;

  // Read response of one register group.
  typedef struct packed {
    logic       hit;
    logic [7:0] data;
  } rd_resp_t;

endpackage

// File: sv/sctio_timers.sv
// Timer bank: enables, prescale counts, targets and 4-bit output counters.
// Depends on sctio_pkg.
module sctio_timers (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exec,
  input  sctio_pkg::in_item_t item,
  output sctio_pkg::rd_resp_t rd,
  output logic [2:0]          timers_enabled
);

  logic       on_r     [sctio_pkg::TIMER_COUNT];
  logic       on_nxt   [sctio_pkg::TIMER_COUNT];
  logic [7:0] pres_r   [sctio_pkg::TIMER_COUNT];
  logic [7:0] pres_nxt [sctio_pkg::TIMER_COUNT];
  logic [7:0] tgt_r    [sctio_pkg::TIMER_COUNT];
  logic [7:0] tgt_nxt  [sctio_pkg::TIMER_COUNT];
  logic [3:0] cnt_r    [sctio_pkg::TIMER_COUNT];
  logic [3:0] cnt_nxt  [sctio_pkg::TIMER_COUNT];

  logic ctrl_wr;
  logic bus_wr;
  logic bus_rd;
  logic tick;

  assign bus_wr  = exec && (item.cmd == sctio_pkg::CMD_WRITE);
  assign bus_rd  = exec && (item.cmd == sctio_pkg::CMD_READ);
  assign tick    = exec && (item.cmd == sctio_pkg::CMD_TICK);
  assign ctrl_wr = bus_wr && (int'(item.reg_offset) == sctio_pkg::OFF_CONTROL);

  always_comb begin
    logic [8:0] sum;
    sum = '0;
    rd  = '0;
    timers_enabled = '0;
    for (int t = 0; t < sctio_pkg::TIMER_COUNT; t++) begin
      on_nxt[t]   = on_r[t];
      pres_nxt[t] = pres_r[t];
      tgt_nxt[t]  = tgt_r[t];
      cnt_nxt[t]  = cnt_r[t];
      // control write: a timer switched on restarts both counts
      if (ctrl_wr && (t < sctio_pkg::CTRL_TIMERS)) begin
        if (item.write_data[t] && !on_r[t]) begin
          pres_nxt[t] = '0;
          cnt_nxt[t]  = '0;
        end
        on_nxt[t] = item.write_data[t];
      end
      // tick: advance prescale, fire on reaching target (zero fires always)
      if (tick && (int'(item.timer_index) == t) && on_r[t]) begin
        sum = {1'b0, pres_r[t]} + 9'd1;
        if (sum >= {1'b0, tgt_r[t]}) begin
          pres_nxt[t] = '0;
          cnt_nxt[t]  = cnt_r[t] + 4'd1;
        end else begin
          pres_nxt[t] = sum[7:0];
        end
      end
      if (bus_wr && (t < sctio_pkg::PAGE_TIMERS) &&
          (int'(item.reg_offset) == sctio_pkg::OFF_TARGET_BASE + t)) begin
        tgt_nxt[t] = item.write_data;
      end
      // read returns the counter and clears it
      if (bus_rd && (int'(item.reg_offset) == sctio_pkg::OFF_COUNT_BASE + t)) begin
        rd.hit      = 1'b1;
        rd.data     = {4'b0000, cnt_r[t]};
        cnt_nxt[t]  = '0;
      end
      if (t < sctio_pkg::PAGE_TIMERS) begin
        timers_enabled[t] = on_nxt[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < sctio_pkg::TIMER_COUNT; t++) begin
      if (!rst_n) begin
        on_r[t]   <= 1'b0;
        pres_r[t] <= '0;
        tgt_r[t]  <= '0;
        cnt_r[t]  <= '0;
      end else begin
        on_r[t]   <= on_nxt[t];
        pres_r[t] <= pres_nxt[t];
        tgt_r[t]  <= tgt_nxt[t];
        cnt_r[t]  <= cnt_nxt[t];
      end
    end
  end

endmodule

// File: sv/sctio_ports.sv
// Host ports, register address latch, control byte and boot ROM flag.
// Depends on sctio_pkg.
module sctio_ports (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exec,
  input  sctio_pkg::in_item_t item,
  output sctio_pkg::rd_resp_t rd,
  output logic                rom_visible
);

  logic [7:0] from_host_r   [sctio_pkg::PORT_COUNT];
  logic [7:0] from_host_nxt [sctio_pkg::PORT_COUNT];
  logic [7:0] to_host_r     [sctio_pkg::PORT_COUNT];
  logic [7:0] to_host_nxt   [sctio_pkg::PORT_COUNT];
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic       rom_r, rom_nxt;

  logic bus_wr;
  logic bus_rd;
  logic host_wr;
  logic ctrl_wr;
  int   off;

  assign off     = int'(item.reg_offset);
  assign bus_wr  = exec && (item.cmd == sctio_pkg::CMD_WRITE);
  assign bus_rd  = exec && (item.cmd == sctio_pkg::CMD_READ);
  assign host_wr = exec && (item.cmd == sctio_pkg::CMD_HOST);
  assign ctrl_wr = bus_wr && (off == sctio_pkg::OFF_CONTROL);

  always_comb begin
    addr_nxt = addr_r;
    ctrl_nxt = ctrl_r;
    rom_nxt  = rom_r;
    rd       = '0;
    if (bus_wr && (off == sctio_pkg::OFF_ADDR)) begin
      addr_nxt = item.write_data;
    end
    if (ctrl_wr) begin
      ctrl_nxt = item.write_data;
      rom_nxt  = item.write_data[sctio_pkg::CTRL_ROM_BIT];
    end
    if (bus_rd && (off == sctio_pkg::OFF_ADDR)) begin
      rd.hit  = 1'b1;
      rd.data = addr_r;
    end
    for (int p = 0; p < sctio_pkg::PORT_COUNT; p++) begin
      from_host_nxt[p] = from_host_r[p];
      to_host_nxt[p]   = to_host_r[p];
      if (host_wr && (off == p)) begin
        from_host_nxt[p] = item.write_data;
      end
      if (bus_wr && (p < 4) && (off == sctio_pkg::OFF_PORT_BASE + p)) begin
        to_host_nxt[p] = item.write_data;
      end
      // control bits 4 and 5 clear port pairs in both directions
      if (ctrl_wr &&
          (((p < 2) && item.write_data[sctio_pkg::CTRL_CLR_LO_BIT]) ||
           ((p >= 2) && (p < 4) && item.write_data[sctio_pkg::CTRL_CLR_HI_BIT]))) begin
        from_host_nxt[p] = '0;
        to_host_nxt[p]   = '0;
      end
      if (bus_rd && (p < 4) && (off == sctio_pkg::OFF_PORT_BASE + p)) begin
        rd.hit  = 1'b1;
        rd.data = from_host_r[p];
      end
    end
  end

  assign rom_visible = rom_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      ctrl_r <= '0;
      rom_r  <= 1'b1;
      for (int p = 0; p < sctio_pkg::PORT_COUNT; p++) begin
        from_host_r[p] <= '0;
        to_host_r[p]   <= '0;
      end
    end else begin
      addr_r <= addr_nxt;
      ctrl_r <= ctrl_nxt;
      rom_r  <= rom_nxt;
      for (int p = 0; p < sctio_pkg::PORT_COUNT; p++) begin
        from_host_r[p] <= from_host_nxt[p];
        to_host_r[p]   <= to_host_nxt[p];
      end
    end
  end

endmodule

// File: sv/sound_cpu_timer_io_block.sv
// Top level of the sound CPU timer and I/O register block.
// Depends on sctio_pkg, sctio_timers and sctio_ports.

// Each request (bus read, bus write, timer tick or host port write) is
// captured in an input register, executed against the timer bank and the
// port registers once the output register is free or being drained, and
// its single response lands in an output register. One request enters per
// cycle while the output is not stalled; the response stays on out_valid
// until out_ready takes it. Both state updates and response selection
// happen in one short pass between the input and output registers, so
// back-to-back requests see each other's effects in order. The output
// register lets a new request enter while a finished response still waits
// for out_ready. Reads of unmapped offsets return 0xff, non-read requests
// return 0; rom_visible and timers_enabled reflect the state after the
// request. After reset the boot ROM is shown and all timers are off; there
// is no clearing pass.
module sound_cpu_timer_io_block (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sctio_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sctio_pkg::out_item_t out_data
);

  sctio_pkg::in_item_t  item_r;
  logic                 item_valid_r;
  sctio_pkg::out_item_t res_r, res_nxt;
  logic                 res_valid_r;

  logic                 adv;
  logic                 exec;
  sctio_pkg::rd_resp_t  tmr_rd;
  sctio_pkg::rd_resp_t  prt_rd;
  logic [2:0]           tmr_en;
  logic                 rom_vis;

  // Advance the pipe whenever the output register is free or being drained.
  assign adv      = !res_valid_r || out_ready;
  assign exec     = item_valid_r && adv;
  assign in_ready = !item_valid_r || adv;

  sctio_timers u_timers (
    .clk            (clk),
    .rst_n          (rst_n),
    .exec           (exec),
    .item           (item_r),
    .rd             (tmr_rd),
    .timers_enabled (tmr_en)
  );

  sctio_ports u_ports (
    .clk         (clk),
    .rst_n       (rst_n),
    .exec        (exec),
    .item        (item_r),
    .rd          (prt_rd),
    .rom_visible (rom_vis)
  );

  // Build the response: reads pick whichever group claims the offset (0xff
  // if none claims it), every other request reads back zero.
  always_comb begin
    res_nxt.rom_visible    = rom_vis;
    res_nxt.timers_enabled = tmr_en;
    if (item_r.cmd != sctio_pkg::CMD_READ) begin
      res_nxt.read_data = '0;
    end else if (prt_rd.hit) begin
      res_nxt.read_data = prt_rd.data;
    end else if (tmr_rd.hit) begin
      res_nxt.read_data = tmr_rd.data;
    end else begin
      res_nxt.read_data = sctio_pkg::UNMAPPED_BYTE;
    end
  end

  // Input register: hold the request until it executes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // Output register: hold the response until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= item_valid_r;
    end
    if (exec) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // A request that is not a read always answers zero.
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (item_r.cmd != sctio_pkg::CMD_READ) |=> (out_data.read_data == 8'h00))
    else $error("non-read request produced nonzero read data");

  // An executed request always leaves a response in the output register.
  a_exec_fills: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid)
    else $error("executed request left no response");

  // Never accept a request while the input register is full and stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !adv |-> !in_ready)
    else $error("input register overrun");

endmodule
